/* design/cpre_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cpre_pkg
// Shared types and constants of the clipped pixel run extractor.
// ----------------------------------------------------------------------------
package cpre_pkg;

	// default largest tile or window dimension
	localparam int MAX_DIM_DEF = 2048;
	// largest number of used bytes in a pixel word
	localparam int MAX_BYTES = 4;

	// fixed field widths
	localparam int PIX_W   = 32;
	localparam int START_W = 22;
	localparam int LEN_W   = 12;
	localparam int RUNS_W  = 22;
	localparam int KEPT_W  = 23;
	localparam int CFG_W   = 12;
	localparam int IDX_W   = 3;
	localparam int BPP_W   = 3;

	// configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_BPP,
		REG_ORIGIN_X,
		REG_ORIGIN_Y,
		REG_TILE_W,
		REG_TILE_H,
		REG_WIN_W,
		REG_WIN_H,
		REG_KEEP_ALL
	} reg_idx_t;

	// result kinds
	typedef enum logic {
		KIND_PIXEL,
		KIND_HEADER
	} kind_t;

	// raw configuration register values
	typedef struct packed {
		logic [BPP_W-1:0] bpp;
		logic [CFG_W-1:0] origin_x;
		logic [CFG_W-1:0] origin_y;
		logic [CFG_W-1:0] tile_w;
		logic [CFG_W-1:0] tile_h;
		logic [CFG_W-1:0] win_w;
		logic [CFG_W-1:0] win_h;
		logic             keep_all;
	} cfg_t;

	// one result item
	typedef struct packed {
		kind_t              kind;
		logic [PIX_W-1:0]   value;
		logic [START_W-1:0] start;
		logic [LEN_W-1:0]   length;
		logic [RUNS_W-1:0]  runs;
		logic [KEPT_W-1:0]  kept;
		logic               done;
		logic               last;
	} res_t;

	// all results of one pixel, data word first
	typedef struct packed {
		logic [1:0] count;
		res_t       item0;
		res_t       item1;
	} step_t;

endpackage
`default_nettype wire

/* design/cpre_cfg_regs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cpre_cfg_regs
// Configuration register file, written one register per request.
// ----------------------------------------------------------------------------
module cpre_cfg_regs (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      wr_en,
	input  wire logic [cpre_pkg::IDX_W-1:0] wr_index,
	input  wire logic [cpre_pkg::CFG_W-1:0] wr_data,
	output cpre_pkg::cfg_t                 cfg
);
	import cpre_pkg::*;

	cfg_t cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bpp      <= BPP_W'(1);
			cfg_q.origin_x <= '0;
			cfg_q.origin_y <= '0;
			cfg_q.tile_w   <= CFG_W'(1);
			cfg_q.tile_h   <= CFG_W'(1);
			cfg_q.win_w    <= CFG_W'(1);
			cfg_q.win_h    <= CFG_W'(1);
			cfg_q.keep_all <= 1'b0;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_BPP:      cfg_q.bpp      <= wr_data[BPP_W-1:0];
				REG_ORIGIN_X: cfg_q.origin_x <= wr_data;
				REG_ORIGIN_Y: cfg_q.origin_y <= wr_data;
				REG_TILE_W:   cfg_q.tile_w   <= wr_data;
				REG_TILE_H:   cfg_q.tile_h   <= wr_data;
				REG_WIN_W:    cfg_q.win_w    <= wr_data;
				REG_WIN_H:    cfg_q.win_h    <= wr_data;
				REG_KEEP_ALL: cfg_q.keep_all <= wr_data[0];
				default:      cfg_q          <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

/* design/cpre_run_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cpre_run_core
// Clipping, on test and run tracking for one pixel; holds position and totals.
// ----------------------------------------------------------------------------
module cpre_run_core #(
	parameter int MAX_DIM = cpre_pkg::MAX_DIM_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  cpre_pkg::cfg_t                 cfg,
	input  wire logic                      step_en,
	input  wire logic [cpre_pkg::PIX_W-1:0] pixel,
	output cpre_pkg::step_t                step
);
	import cpre_pkg::*;

	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int COL_W = $clog2(MAX_DIM);
	localparam int CW    = (DIM_W > CFG_W) ? DIM_W : CFG_W;
	localparam int XW    = CW + 2;
	localparam int PW    = COL_W + DIM_W;
	localparam int SW    = (PW + 1 > START_W) ? PW + 1 : START_W;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
		logic [CW-1:0] w;
		logic [CW-1:0] r;
		w = CW'(v);
		if (w == '0)
			r = CW'(1);
		else if (w > CW'(MAX_DIM))
			r = CW'(MAX_DIM);
		else
			r = w;
		return r[DIM_W-1:0];
	endfunction

	logic [COL_W-1:0]   column_q;
	logic [COL_W-1:0]   row_q;
	logic               in_run_q;
	logic [START_W-1:0] run_origin_q;
	logic [LEN_W-1:0]   run_count_q;
	logic [RUNS_W-1:0]  runs_q;
	logic [KEPT_W-1:0]  kept_q;

	logic [DIM_W-1:0]      tw_c, th_c, ww_c, wh_c;
	logic [3:0]            bpp_c;
	logic [PIX_W-1:0]      used;
	logic signed [XW-1:0]  wx, wy, ww_s, wh_s, ww_m1;
	logic                  in_win, on, row_end, tile_end, at_edge;
	logic                  close_edge, close_off, starting;
	logic [PW-1:0]         prod;
	logic [SW-1:0]         org_sum;
	logic [START_W-1:0]    origin_now;
	logic [LEN_W-1:0]      cnt_inc;
	logic [KEPT_W-1:0]     kept_inc;
	res_t                  pix_item, hdr_item;

	// clamp the size and byte count registers
	always_comb begin
		tw_c = clamp_dim(cfg.tile_w);
		th_c = clamp_dim(cfg.tile_h);
		ww_c = clamp_dim(cfg.win_w);
		wh_c = clamp_dim(cfg.win_h);
		if (cfg.bpp == '0)
			bpp_c = 4'd1;
		else if (4'(cfg.bpp) > 4'(MAX_BYTES))
			bpp_c = 4'(MAX_BYTES);
		else
			bpp_c = 4'(cfg.bpp);
	end

	// mask off unused bytes
	always_comb begin
		for (int b = 0; b < PIX_W / 8; b++) begin
			used[8*b +: 8] = (4'(b) < bpp_c) ? pixel[8*b +: 8] : 8'd0;
		end
	end

	// window position and clipping
	assign wx    = $signed({{(XW-CFG_W){cfg.origin_x[CFG_W-1]}}, cfg.origin_x})
	             + $signed({{(XW-COL_W){1'b0}}, column_q});
	assign wy    = $signed({{(XW-CFG_W){cfg.origin_y[CFG_W-1]}}, cfg.origin_y})
	             + $signed({{(XW-COL_W){1'b0}}, row_q});
	assign ww_s  = $signed({{(XW-DIM_W){1'b0}}, ww_c});
	assign wh_s  = $signed({{(XW-DIM_W){1'b0}}, wh_c});
	assign ww_m1 = ww_s - $signed({{(XW-1){1'b0}}, 1'b1});

	assign in_win   = !wx[XW-1] && (wx < ww_s) && !wy[XW-1] && (wy < wh_s);
	assign on       = in_win && (cfg.keep_all || (used != '0));
	assign at_edge  = (wx == ww_m1);
	assign row_end  = ((DIM_W+1)'(column_q) + (DIM_W+1)'(1)) >= (DIM_W+1)'(tw_c);
	assign tile_end = row_end
	               && (((DIM_W+1)'(row_q) + (DIM_W+1)'(1)) >= (DIM_W+1)'(th_c));

	// run start address of the current pixel
	assign prod       = PW'(wy[COL_W-1:0]) * PW'(ww_c);
	assign org_sum    = SW'(prod) + SW'(wx[COL_W-1:0]);
	assign origin_now = org_sum[START_W-1:0];

	// run bookkeeping
	assign starting   = on && !in_run_q;
	assign close_edge = on && (at_edge || row_end);
	assign close_off  = !on && in_run_q;
	assign cnt_inc    = (in_run_q ? run_count_q : LEN_W'(0)) + LEN_W'(1);
	assign kept_inc   = kept_q + KEPT_W'(1);

	// result items
	always_comb begin
		pix_item.kind   = KIND_PIXEL;
		pix_item.value  = used;
		pix_item.start  = '0;
		pix_item.length = '0;
		pix_item.runs   = runs_q;
		pix_item.kept   = kept_inc;
		pix_item.done   = tile_end;
		pix_item.last   = !close_edge;

		hdr_item.kind   = KIND_HEADER;
		hdr_item.value  = '0;
		hdr_item.start  = starting ? origin_now : run_origin_q;
		hdr_item.length = on ? cnt_inc : run_count_q;
		hdr_item.runs   = runs_q + RUNS_W'(1);
		hdr_item.kept   = on ? kept_inc : kept_q;
		hdr_item.done   = tile_end;
		hdr_item.last   = 1'b1;

		if (on) begin
			step.count = close_edge ? 2'd2 : 2'd1;
			step.item0 = pix_item;
		end else begin
			step.count = close_off ? 2'd1 : 2'd0;
			step.item0 = hdr_item;
		end
		step.item1 = hdr_item;
	end

	// position, run and totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q     <= '0;
			row_q        <= '0;
			in_run_q     <= 1'b0;
			run_origin_q <= '0;
			run_count_q  <= '0;
			runs_q       <= '0;
			kept_q       <= '0;
		end else if (step_en) begin
			if (tile_end) begin
				column_q     <= '0;
				row_q        <= '0;
				in_run_q     <= 1'b0;
				run_origin_q <= '0;
				run_count_q  <= '0;
				runs_q       <= '0;
				kept_q       <= '0;
			end else begin
				if (row_end) begin
					column_q <= '0;
					row_q    <= row_q + COL_W'(1);
				end else begin
					column_q <= column_q + COL_W'(1);
				end
				in_run_q <= on && !close_edge;
				if (starting)
					run_origin_q <= origin_now;
				run_count_q <= (on && !close_edge) ? cnt_inc : LEN_W'(0);
				if (close_off || close_edge)
					runs_q <= runs_q + RUNS_W'(1);
				if (on)
					kept_q <= kept_inc;
			end
		end
	end

endmodule
`default_nettype wire

/* design/cpre_out_buf.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cpre_out_buf
// Two-slot result register; a pixel's data word leaves before its header.
// ----------------------------------------------------------------------------
module cpre_out_buf (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  cpre_pkg::step_t step,
	input  wire logic       stall,
	output wire logic       valid,
	output wire logic       room,
	output cpre_pkg::res_t  head
);
	import cpre_pkg::*;

	res_t       slot0_q, slot1_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign valid = (cnt_q != 2'd0);
	assign pop   = valid && !stall;
	// free once the head leaves and nothing is behind it
	assign room  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);
	assign head  = slot0_q;

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= 2'd0;
		else if (push)
			cnt_q <= step.count;
		else if (pop)
			cnt_q <= cnt_q - 2'd1;
	end

	// result slots
	always_ff @(posedge clk) begin
		if (push) begin
			slot0_q <= step.item0;
			slot1_q <= step.item1;
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
	end

endmodule
`default_nettype wire

/* design/clipped_pixel_run_extractor.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// clipped_pixel_run_extractor
// Clips a raster tile to a display window and turns on pixels into data
// words plus run headers, with running run and pixel totals.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  pix      in         pix_valid/pix_stall   pixel_word
//  res      out        res_valid/res_stall   item_kind .. last
//  cfg      in         cfg_valid/cfg_ready   cfg_index, cfg_data
//
//  A pixel is held in the input register and processed into the result register.
//  One pixel per clock while res_stall is low and no pixel gives two results;
//  a pixel that gives a data word and a header fills both result slots, so the
//  next pixel waits in the input register until the data word has left.
//  Reset sets the registers to their defaults and clears position and totals.
//  res_stall reaches pix_stall in the same cycle through the result register.
// ----------------------------------------------------------------------------
module clipped_pixel_run_extractor #(
	parameter int MAX_DIM = cpre_pkg::MAX_DIM_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        pix_valid,
	output wire logic                        pix_stall,
	input  wire logic [cpre_pkg::PIX_W-1:0]   pixel_word,
	output wire logic                        res_valid,
	input  wire logic                        res_stall,
	output wire logic                        item_kind,
	output wire logic [cpre_pkg::PIX_W-1:0]   pixel_value,
	output wire logic [cpre_pkg::START_W-1:0] run_start,
	output wire logic [cpre_pkg::LEN_W-1:0]   run_length,
	output wire logic [cpre_pkg::RUNS_W-1:0]  runs_total,
	output wire logic [cpre_pkg::KEPT_W-1:0]  on_total,
	output wire logic                        tile_done,
	output wire logic                        last,
	input  wire logic                        cfg_valid,
	output wire logic                        cfg_ready,
	input  wire logic [cpre_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [cpre_pkg::CFG_W-1:0]   cfg_data
);
	import cpre_pkg::*;

	cfg_t             cfg;
	step_t            step;
	res_t             head;
	logic             vld_s1;
	logic [PIX_W-1:0] pix_s1;
	logic             room, proc, pix_take;

	assign cfg_ready = 1'b1;

	cpre_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// input register
	assign proc      = vld_s1 && room;
	assign pix_stall = vld_s1 && !proc;
	assign pix_take  = pix_valid && !pix_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (pix_take)
			vld_s1 <= 1'b1;
		else if (proc)
			vld_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pix_take)
			pix_s1 <= pixel_word;
	end

	cpre_run_core #(
		.MAX_DIM (MAX_DIM)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.step_en (proc),
		.pixel   (pix_s1),
		.step    (step)
	);

	cpre_out_buf u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (proc),
		.step   (step),
		.stall  (res_stall),
		.valid  (res_valid),
		.room   (room),
		.head   (head)
	);

	// result ports
	assign item_kind   = head.kind;
	assign pixel_value = head.value;
	assign run_start   = head.start;
	assign run_length  = head.length;
	assign runs_total  = head.runs;
	assign on_total    = head.kept;
	assign tile_done   = head.done;
	assign last        = head.last;

`ifndef SYNTHESIS
	// a header always closes the results of its pixel
	a_header_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && head.kind == KIND_HEADER) |-> head.last)
		else $error("run header not marked last");

	// a data word that is not last is followed by its header
	a_word_then_header: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_stall && head.kind == KIND_PIXEL && !head.last)
		|=> (res_valid && head.kind == KIND_HEADER))
		else $error("data word not followed by its run header");

	// input stalls only while a pixel waits in the input register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> (vld_s1 && !room))
		else $error("input stalled with free input register");
`endif

endmodule
`default_nettype wire

/* tb/sv/cpre_run_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cpre_run_checker
// Watches the pixel, result and register channels of the clipped pixel run
// extractor. Keeps its own copy of the registers and the tile position, works
// out the data words and run headers of every accepted pixel request, and
// compares each accepted result field by field with the oldest one due.
// ----------------------------------------------------------------------------
module cpre_run_checker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            pix_valid,
	input  wire logic                            pix_stall,
	input  wire logic [cpre_pkg::PIX_W-1:0]      pixel_word,
	input  wire logic                            res_valid,
	input  wire logic                            res_stall,
	input  wire logic                            item_kind,
	input  wire logic [cpre_pkg::PIX_W-1:0]      pixel_value,
	input  wire logic [cpre_pkg::START_W-1:0]    run_start,
	input  wire logic [cpre_pkg::LEN_W-1:0]      run_length,
	input  wire logic [cpre_pkg::RUNS_W-1:0]     runs_total,
	input  wire logic [cpre_pkg::KEPT_W-1:0]     on_total,
	input  wire logic                            tile_done,
	input  wire logic                            last,
	input  wire logic                            cfg_valid,
	input  wire logic                            cfg_ready,
	input  wire logic [cpre_pkg::IDX_W-1:0]      cfg_index,
	input  wire logic [cpre_pkg::CFG_W-1:0]      cfg_data,
	output int unsigned                          mismatches,
	output int unsigned                          backlog,
	output int unsigned                          words_seen,
	output int unsigned                          headers_seen,
	output int unsigned                          tiles_seen
);
	import cpre_pkg::*;

	// register copy and tile state
	cfg_t               shadow_cfg;
	logic [10:0]        col_pos;
	logic [10:0]        row_pos;
	logic               run_open;
	logic [START_W-1:0] run_origin;
	logic [LEN_W-1:0]   run_len;
	logic [RUNS_W-1:0]  runs_count;
	logic [KEPT_W-1:0]  kept_count;

	// data words and headers still to come out, oldest first
	res_t               run_words_due[$];
	res_t               oldest;

	// size registers are held to 1 .. MAX_DIM
	function automatic int clamp_dim(input logic [CFG_W-1:0] v);
		int d;
		d = int'(v);
		if (d < 1) d = 1;
		if (d > MAX_DIM_DEF) d = MAX_DIM_DEF;
		return d;
	endfunction

	// result carrying the current totals
	function automatic res_t make_item(input kind_t kind, input logic [PIX_W-1:0] value,
		input logic [START_W-1:0] start, input logic [LEN_W-1:0] length);
		res_t item;
		item = '0;
		item.kind = kind;
		item.value = value;
		item.start = start;
		item.length = length;
		item.runs = runs_count;
		item.kept = kept_count;
		return item;
	endfunction

	// finish the open run with a header
	task automatic close_run(output res_t item);
		runs_count++;
		item = make_item(KIND_HEADER, '0, run_origin, run_len);
		run_open = 1'b0;
		run_len = '0;
	endtask

	// clip one pixel to the window and encode it
	task automatic encode_pixel(input logic [PIX_W-1:0] word);
		int bytes, tw, th, ww, wh, wx, wy, n, k;
		logic [PIX_W-1:0] used;
		logic in_win, row_end, tile_end;
		res_t outs [2];
		bytes = int'(shadow_cfg.bpp);
		if (bytes < 1) bytes = 1;
		if (bytes > MAX_BYTES) bytes = MAX_BYTES;
		used = (bytes >= 4) ? word : word & ((32'd1 << (8 * bytes)) - 32'd1);
		tw = clamp_dim(shadow_cfg.tile_w);
		th = clamp_dim(shadow_cfg.tile_h);
		ww = clamp_dim(shadow_cfg.win_w);
		wh = clamp_dim(shadow_cfg.win_h);
		wx = int'($signed(shadow_cfg.origin_x)) + int'(col_pos);
		wy = int'($signed(shadow_cfg.origin_y)) + int'(row_pos);
		in_win = wx >= 0 && wx < ww && wy >= 0 && wy < wh;
		row_end = int'(col_pos) + 1 >= tw;
		tile_end = row_end && (int'(row_pos) + 1 >= th);
		n = 0;
		outs[0] = '0;
		outs[1] = '0;
		if (in_win) begin
			// on pixel opens or extends a run, off pixel ends it
			if (shadow_cfg.keep_all || used != '0) begin
				if (!run_open) begin
					run_open = 1'b1;
					run_origin = START_W'(wy * ww + wx);
					run_len = '0;
				end
				run_len++;
				kept_count++;
				outs[n] = make_item(KIND_PIXEL, used, '0, '0);
				n++;
			end else if (run_open) begin
				close_run(outs[n]);
				n++;
			end
			// right window edge or end of tile row
			if (run_open && (wx == ww - 1 || row_end)) begin
				close_run(outs[n]);
				n++;
			end
		end else if (run_open) begin
			// dropped pixel ends an open run
			close_run(outs[n]);
			n++;
		end
		for (k = 0; k < n; k++) begin
			outs[k].done = tile_end;
			outs[k].last = (k == n - 1);
			run_words_due.push_back(outs[k]);
		end
		// advance the tile position
		if (row_end) begin
			col_pos = '0;
			row_pos = (int'(row_pos) + 1 >= th) ? '0 : row_pos + 1'b1;
		end else begin
			col_pos = col_pos + 1'b1;
		end
		if (tile_end) begin
			col_pos = '0;
			row_pos = '0;
			run_open = 1'b0;
			run_origin = '0;
			run_len = '0;
			runs_count = '0;
			kept_count = '0;
		end
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	// watch all three channels
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_cfg = '0;
			shadow_cfg.bpp = 3'd1;
			shadow_cfg.tile_w = 12'd1;
			shadow_cfg.tile_h = 12'd1;
			shadow_cfg.win_w = 12'd1;
			shadow_cfg.win_h = 12'd1;
			col_pos = '0;
			row_pos = '0;
			run_open = 1'b0;
			run_origin = '0;
			run_len = '0;
			runs_count = '0;
			kept_count = '0;
			run_words_due.delete();
			mismatches = 0;
			words_seen = 0;
			headers_seen = 0;
			tiles_seen = 0;
			backlog <= 0;
		end else begin
			// register write request
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_BPP:      shadow_cfg.bpp = cfg_data[BPP_W-1:0];
					REG_ORIGIN_X: shadow_cfg.origin_x = cfg_data;
					REG_ORIGIN_Y: shadow_cfg.origin_y = cfg_data;
					REG_TILE_W:   shadow_cfg.tile_w = cfg_data;
					REG_TILE_H:   shadow_cfg.tile_h = cfg_data;
					REG_WIN_W:    shadow_cfg.win_w = cfg_data;
					REG_WIN_H:    shadow_cfg.win_h = cfg_data;
					REG_KEEP_ALL: shadow_cfg.keep_all = cfg_data[0];
					default: ;
				endcase
			end
			// pixel request
			if (pix_valid && !pix_stall)
				encode_pixel(pixel_word);
			// result request
			if (res_valid && !res_stall) begin
				if (run_words_due.size() == 0) begin
					$error("result with no request pending: item_kind %0d", item_kind);
					mismatches++;
				end else begin
					oldest = run_words_due.pop_front();
					compare_field("item_kind", 32'(oldest.kind), 32'(item_kind));
					compare_field("pixel_value", oldest.value, pixel_value);
					compare_field("run_start", 32'(oldest.start), 32'(run_start));
					compare_field("run_length", 32'(oldest.length), 32'(run_length));
					compare_field("runs_total", 32'(oldest.runs), 32'(runs_total));
					compare_field("on_total", 32'(oldest.kept), 32'(on_total));
					compare_field("tile_done", 32'(oldest.done), 32'(tile_done));
					compare_field("last", 32'(oldest.last), 32'(last));
				end
				if (item_kind == KIND_HEADER) headers_seen++;
				else words_seen++;
				if (tile_done && last) tiles_seen++;
			end
			backlog <= run_words_due.size();
		end
	end

endmodule

/* tb/sv/clipped_pixel_run_extractor_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// clipped_pixel_run_extractor_tb
// Drives pixel streams through the run extractor under many window and tile
// settings, with random gaps on the pixel side and random stalls on the
// result side. A directed opening covers clipping at every border, off and
// on pixels, size and byte count clamping and a mid-tile register change;
// random phases follow. The checker beside the block does all prediction.
// ----------------------------------------------------------------------------
module clipped_pixel_run_extractor_tb;
	import cpre_pkg::*;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                pix_valid;
	logic [PIX_W-1:0]    pixel_word;
	logic                res_stall;
	logic                cfg_valid;
	logic [IDX_W-1:0]    cfg_index;
	logic [CFG_W-1:0]    cfg_data;
	wire logic           pix_stall;
	wire logic           res_valid;
	wire logic           item_kind;
	wire logic [PIX_W-1:0]   pixel_value;
	wire logic [START_W-1:0] run_start;
	wire logic [LEN_W-1:0]   run_length;
	wire logic [RUNS_W-1:0]  runs_total;
	wire logic [KEPT_W-1:0]  on_total;
	wire logic           tile_done;
	wire logic           last;
	wire logic           cfg_ready;

	int unsigned         mismatches;
	int unsigned         backlog;
	int unsigned         words_seen;
	int unsigned         headers_seen;
	int unsigned         tiles_seen;

	bit                  no_idle;
	int unsigned         pixels_sent;
	int unsigned         settings;

	clipped_pixel_run_extractor dut (.*);

	cpre_run_checker checker_i (.*);

	// clock
	always #6 clk = ~clk;

	// write the selected registers, one request each
	task automatic apply_config(input cfg_t c, input logic [7:0] which);
		int i;
		logic [CFG_W-1:0] value;
		for (i = 0; i < 8; i++) begin
			if (which[i]) begin
				case (reg_idx_t'(i))
					REG_BPP:      value = {9'($urandom()), c.bpp};
					REG_ORIGIN_X: value = c.origin_x;
					REG_ORIGIN_Y: value = c.origin_y;
					REG_TILE_W:   value = c.tile_w;
					REG_TILE_H:   value = c.tile_h;
					REG_WIN_W:    value = c.win_w;
					REG_WIN_H:    value = c.win_h;
					REG_KEEP_ALL: value = {11'($urandom()), c.keep_all};
					default:      value = '0;
				endcase
				cfg_valid <= 1'b1;
				cfg_index <= reg_idx_t'(i);
				cfg_data <= value;
				do @(posedge clk); while (!cfg_ready);
			end
		end
		cfg_valid <= 1'b0;
		settings++;
	endtask

	// one pixel request after a random gap
	task automatic send_pixel(input logic [PIX_W-1:0] word);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_valid <= 1'b1;
		pixel_word <= word;
		do @(posedge clk); while (pix_stall);
		pixels_sent++;
	endtask

	// drop valid, wait for every result, then let the pipeline empty
	task automatic settle();
		pix_valid <= 1'b0;
		@(posedge clk);
		while (backlog != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// result side with random stalls
	initial begin : result_sink
		int hold;
		res_stall <= 1'b0;
		@(posedge clk);
		forever begin
			hold = no_idle ? 0 : $urandom_range(0, 16);
			if (hold > 0) begin
				res_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			res_stall <= 1'b0;
			do @(posedge clk); while (!res_valid);
		end
	end

	// run limit
	initial begin : watchdog
		#10_000_000;
		$display("run limit reached with %0d results pending", backlog);
		$display("*** FAILED ***");
		$finish;
	end

	// stimulus
	initial begin : stimulus
		cfg_t setup;
		int count, sent_random, streak_left;
		bit big, streak_on;
		logic [7:0] which;
		logic [PIX_W-1:0] word;
		pixels_sent = 0;
		settings = 0;
		no_idle = 1'b0;
		streak_left = 0;
		streak_on = 1'b0;
		sent_random = 0;
		arst_n <= 1'b0;
		pix_valid <= 1'b0;
		pixel_word <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_BPP;
		cfg_data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: single pixel tile and window, one used byte
		send_pixel(32'h0000_0000);
		send_pixel(32'h0000_00FF);
		send_pixel(32'hFFFF_FF00);
		settle();

		// left column clipped, bottom row clipped, runs ended by off pixel and edge
		setup = '0;
		setup.bpp = 3'd4;
		setup.origin_x = -12'sd1;
		setup.origin_y = 12'd0;
		setup.tile_w = 12'd5;
		setup.tile_h = 12'd2;
		setup.win_w = 12'd4;
		setup.win_h = 12'd1;
		setup.keep_all = 1'b0;
		apply_config(setup, 8'hFF);
		send_pixel(32'hFFFF_FFFF);
		send_pixel(32'h8000_0000);
		send_pixel(32'h0000_0000);
		send_pixel(32'h0000_0001);
		send_pixel(32'h00FF_0000);
		send_pixel(32'hFFFF_FFFF);
		send_pixel(32'h0000_0000);
		send_pixel(32'hA5A5_A5A5);
		send_pixel(32'h5A5A_5A5A);
		send_pixel(32'hFFFF_FFFF);
		settle();

		// clamped sizes and byte count, keep whole rows, last window column
		setup.bpp = 3'd7;
		setup.origin_x = 12'sd2047;
		setup.origin_y = 12'd0;
		setup.tile_w = 12'd0;
		setup.tile_h = 12'd3;
		setup.win_w = 12'hFFF;
		setup.win_h = 12'd0;
		setup.keep_all = 1'b1;
		apply_config(setup, 8'hFF);
		repeat (3) send_pixel(32'h0000_0000);
		settle();

		// tile entirely outside the window
		setup.bpp = 3'd2;
		setup.origin_x = 12'h800;
		setup.origin_y = 12'h800;
		setup.tile_w = 12'd4;
		setup.tile_h = 12'd1;
		setup.win_w = 12'd1;
		setup.win_h = 12'd1;
		setup.keep_all = 1'b0;
		apply_config(setup, 8'hFF);
		send_pixel(32'hFFFF_FFFF);
		send_pixel(32'h0000_0001);
		send_pixel(32'h8000_0000);
		send_pixel(32'h0101_0101);
		settle();

		// open run closed by a register change that moves the window away
		setup.bpp = 3'd3;
		setup.origin_x = 12'd0;
		setup.origin_y = 12'd0;
		setup.tile_w = 12'd8;
		setup.tile_h = 12'd1;
		setup.win_w = 12'd8;
		setup.win_h = 12'd1;
		apply_config(setup, 8'hFF);
		send_pixel(32'h0001_0000);
		send_pixel(32'h0000_0100);
		settle();
		setup.origin_x = 12'd100;
		apply_config(setup, 8'h02);
		send_pixel(32'hFFFF_FFFF);
		settle();
		// narrower tile makes the current column end the tile
		setup.tile_w = 12'd2;
		apply_config(setup, 8'h08);
		send_pixel(32'h0000_0000);
		settle();

		// random phases: mostly small tiles, a few huge or out-of-range ones
		while (sent_random < 1800) begin
			big = ($urandom_range(0, 7) == 0);
			setup.bpp = ($urandom_range(0, 3) == 0) ? BPP_W'($urandom_range(0, 7))
				: BPP_W'($urandom_range(1, 4));
			setup.keep_all = ($urandom_range(0, 3) == 0);
			if (big) begin
				setup.origin_x = CFG_W'($urandom());
				setup.origin_y = CFG_W'($urandom());
				setup.tile_w = CFG_W'($urandom());
				setup.tile_h = CFG_W'($urandom());
				setup.win_w = CFG_W'($urandom());
				setup.win_h = CFG_W'($urandom());
			end else begin
				setup.origin_x = CFG_W'(int'($urandom_range(0, 18)) - 6);
				setup.origin_y = CFG_W'(int'($urandom_range(0, 10)) - 3);
				setup.tile_w = CFG_W'($urandom_range(1, 12));
				setup.tile_h = CFG_W'($urandom_range(1, 6));
				setup.win_w = CFG_W'($urandom_range(1, 12));
				setup.win_h = CFG_W'($urandom_range(1, 8));
			end
			// now and then only one register changes, mid-tile
			which = ($urandom_range(0, 3) == 0) ? 8'(1 << $urandom_range(0, 7)) : 8'hFF;
			apply_config(setup, which);
			no_idle = ($urandom_range(0, 4) == 0);
			if (!big && which == 8'hFF && $urandom_range(0, 2) != 0)
				count = int'(setup.tile_w) * int'(setup.tile_h) * $urandom_range(1, 3);
			else
				count = $urandom_range(1, 40);
			repeat (count) begin
				// streaks of on and off pixels form runs
				if (streak_left == 0) begin
					streak_on = ($urandom_range(0, 2) != 0);
					streak_left = $urandom_range(1, 8);
				end
				streak_left--;
				if (streak_on)
					word = ($urandom_range(0, 3) == 0)
						? (32'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3)))
						: $urandom();
				else
					word = ($urandom_range(0, 1) == 0) ? 32'h0
						: ($urandom() << (8 * $urandom_range(1, 3)));
				send_pixel(word);
			end
			sent_random += count;
			settle();
		end

		no_idle = 1'b0;
		settle();
		$display("covered %0d pixel requests under %0d register settings", pixels_sent,
			settings);
		$display("checked %0d data words and %0d run headers, %0d tiles finished with results",
			words_seen, headers_seen, tiles_seen);
		if (mismatches == 0 && backlog == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

/* files.f */
design/cpre_pkg.sv
design/cpre_cfg_regs.sv
design/cpre_run_core.sv
design/cpre_out_buf.sv
design/clipped_pixel_run_extractor.sv
tb/sv/cpre_run_checker.sv
tb/sv/clipped_pixel_run_extractor_tb.sv
